// ----- rtl/tcw_pkg.sv -----
// Shared types and constants of the text console cell writer.
package tcw_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WCHAR,
      ST_WRAP,
      ST_CHKROW,
      ST_SCROLL,
      ST_ROWCLR,
      ST_AFTER,
      ST_REDUCE,
      ST_READ,
      ST_DONE
   } state_type;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_TAKE  = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [1:0] REG_COLS = 2'd0;
   localparam logic [1:0] REG_ROWS = 2'd1;
   localparam logic [1:0] REG_FORE = 2'd2;
   localparam logic [1:0] REG_BACK = 2'd3;

   localparam logic [15:0] CODE_BS    = 16'd8;
   localparam logic [15:0] CODE_NL    = 16'd10;
   localparam logic [15:0] CODE_LIMIT = 16'd255;
   localparam logic [7:0]  CHAR_BLOCK = 8'hDB;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_EMPTY = 8'h00;

   localparam logic [7:0]  COLS_RST = 8'd80;
   localparam logic [6:0]  ROWS_RST = 7'd25;
   localparam logic [31:0] FORE_RST = 32'h00FF_FFFF;
   localparam logic [31:0] BACK_RST = 32'h0000_0000;

endpackage

// ----- rtl/text_console_cell_writer.sv -----
// From the input transfer to the result register: put character or backspace writes
// the cell and checks for a wrap; a scroll also clears the new bottom row one column at
// a time. Newline checks the row and scrolls the same way. Backspace at the home cell
// and take dirty rectangle go straight to the result. Read cell folds MAX_ROWS or MAX_COLS
// out of the read position, then reads; clear screen writes every cell. One item at a
// time; a held result stalls the next. Reset clears the store before any transfer.
module text_console_cell_writer #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_char_code,
   input  logic [5:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_caret_col,
   output logic [5:0]  rsp_caret_row,
   output logic [5:0]  rsp_top_row,
   output logic        rsp_dirty_valid,
   output logic [6:0]  rsp_dirty_col_first,
   output logic [5:0]  rsp_dirty_row_first,
   output logic [7:0]  rsp_dirty_col_end,
   output logic [6:0]  rsp_dirty_row_end,
   output logic [7:0]  rsp_cell_char,
   output logic [31:0] rsp_cell_fore,
   output logic [31:0] rsp_cell_back,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Widths that follow from the screen limits. The caret registers carry one extra
   // bit because a column or row briefly reaches the limit before it wraps.
   localparam int CW    = $clog2(MAX_COLS);
   localparam int CW1   = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int RW1   = $clog2(MAX_ROWS + 1);
   localparam int RS    = RW + 1;
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);

   typedef struct packed {
      logic           empty;
      logic [CW-1:0]  x0;
      logic [RW-1:0]  y0;
      logic [CW1-1:0] x1;
      logic [RW1-1:0] y1;
   } dirty_type;

   typedef struct packed {
      logic [CW1-1:0] x;
      logic [RW1-1:0] y;
   } caret_type;

   // Clamp the configured sizes to the range the store supports.
   function automatic logic [CW1-1:0] eff_cols_f(input logic [7:0] c);
      logic [CW1-1:0] r;
      if (c == 8'd0) begin
         r = CW1'(1);
      end else if (32'(c) > MAX_COLS) begin
         r = CW1'(MAX_COLS);
      end else begin
         r = CW1'(c);
      end
      return r;
   endfunction

   function automatic logic [RW1-1:0] eff_rows_f(input logic [6:0] c);
      logic [RW1-1:0] r;
      if (c == 7'd0) begin
         r = RW1'(1);
      end else if (32'(c) > MAX_ROWS) begin
         r = RW1'(MAX_ROWS);
      end else begin
         r = RW1'(c);
      end
      return r;
   endfunction

   // Sum of two ring rows, both below MAX_ROWS, folded back into the ring.
   function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a, input logic [RW-1:0] b);
      logic [RS-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= RS'(MAX_ROWS)) begin
         s = s - RS'(MAX_ROWS);
      end
      return RW'(s);
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col);
      return AW'(row) * AW'(MAX_COLS) + AW'(col);
   endfunction

   // Grow the dirty rectangle to cover the caret cell.
   function automatic dirty_type mark_at(input dirty_type d, input logic [CW1-1:0] cx,
                                         input logic [RW1-1:0] cy);
      dirty_type     r;
      logic [CW-1:0] x;
      logic [RW-1:0] y;
      x = CW'(cx);
      y = RW'(cy);
      r = d;
      if (d.empty) begin
         r.empty = 1'b0;
         r.x0    = x;
         r.y0    = y;
         r.x1    = CW1'(x) + CW1'(1);
         r.y1    = RW1'(y) + RW1'(1);
      end else begin
         if (x < d.x0) r.x0 = x;
         if (y < d.y0) r.y0 = y;
         if (CW1'(x) + CW1'(1) > d.x1) r.x1 = CW1'(x) + CW1'(1);
         if (RW1'(y) + RW1'(1) > d.y1) r.y1 = RW1'(y) + RW1'(1);
      end
      return r;
   endfunction

   // One cell back; from column 0 this is the last column of the row above.
   function automatic caret_type step_back(input caret_type c, input logic [CW1-1:0] ec);
      caret_type r;
      r = c;
      if (c.x != '0) begin
         r.x = c.x - CW1'(1);
      end else if (c.y != '0) begin
         r.y = c.y - RW1'(1);
         r.x = ec - CW1'(1);
      end
      return r;
   endfunction

   // Cell store: characters in one memory, the two colors in the other, so that a
   // scroll can clear the characters of a row and keep its colors.
   logic [7:0]  char_mem  [CELLS];
   logic [63:0] color_mem [CELLS];

   tcw_pkg::state_type state_ff, state_in;

   logic [7:0]     cols_ff, cols_in;
   logic [6:0]     rows_ff, rows_in;
   logic [31:0]    fore_ff, fore_in;
   logic [31:0]    back_ff, back_in;
   caret_type      caret_ff, caret_in;
   logic [RW-1:0]  top_ff, top_in;
   dirty_type      dirty_ff, dirty_in;
   logic [1:0]     mode_ff, mode_in;
   logic [7:0]     wch_ff, wch_in;
   logic           bs_ff, bs_in;
   logic           nl_mark_ff, nl_mark_in;
   logic           init_ff, init_in;
   logic [5:0]     rrow_ff, rrow_in;
   logic [6:0]     rcol_ff, rcol_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [CW-1:0]  col_cnt_ff, col_cnt_in;
   logic [31:0]    clr_fore_ff, clr_fore_in;
   logic [31:0]    clr_back_ff, clr_back_in;
   logic [7:0]     rd_char_ff;
   logic [63:0]    rd_color_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [6:0]     rsp_caret_col_ff, rsp_caret_col_in;
   logic [5:0]     rsp_caret_row_ff, rsp_caret_row_in;
   logic [5:0]     rsp_top_row_ff, rsp_top_row_in;
   logic           rsp_dv_ff, rsp_dv_in;
   logic [6:0]     rsp_dcf_ff, rsp_dcf_in;
   logic [5:0]     rsp_drf_ff, rsp_drf_in;
   logic [7:0]     rsp_dce_ff, rsp_dce_in;
   logic [6:0]     rsp_dre_ff, rsp_dre_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic [31:0]    rsp_fore_ff, rsp_fore_in;
   logic [31:0]    rsp_back_ff, rsp_back_in;

   // Memory port controls.
   logic           ch_we;
   logic [AW-1:0]  ch_wa;
   logic [7:0]     ch_wd;
   logic           co_we;
   logic [AW-1:0]  co_wa;
   logic [63:0]    co_wd;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;

   logic [CW1-1:0] eff_c;
   logic [RW1-1:0] eff_r;
   logic           req_xfer;
   logic           rsp_free;
   logic           row_big;
   logic           col_big;
   logic           sweep_last;
   logic           rowclr_last;
   logic           bs_noop;

   assign eff_c       = eff_cols_f(cols_ff);
   assign eff_r       = eff_rows_f(rows_ff);
   assign req_ready   = (state_ff == tcw_pkg::ST_IDLE);
   assign req_xfer    = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign row_big     = 32'(rrow_ff) >= MAX_ROWS;
   assign col_big     = 32'(rcol_ff) >= MAX_COLS;
   assign sweep_last  = (32'(sweep_ff) == CELLS - 1);
   assign rowclr_last = (32'(col_cnt_ff) == MAX_COLS - 1);
   assign bs_noop     = (caret_ff.x == '0) && (caret_ff.y == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (req_mode)
                  tcw_pkg::MODE_PUT: begin
                     if (req_char_code == tcw_pkg::CODE_NL) begin
                        state_in = tcw_pkg::ST_CHKROW;
                     end else if (req_char_code == tcw_pkg::CODE_BS) begin
                        state_in = bs_noop ? tcw_pkg::ST_DONE : tcw_pkg::ST_WCHAR;
                     end else begin
                        state_in = tcw_pkg::ST_WCHAR;
                     end
                  end
                  tcw_pkg::MODE_CLEAR: state_in = tcw_pkg::ST_CLEAR;
                  tcw_pkg::MODE_TAKE:  state_in = tcw_pkg::ST_DONE;
                  default:             state_in = tcw_pkg::ST_REDUCE;
               endcase
            end
         end
         tcw_pkg::ST_CLEAR: begin
            if (sweep_last) begin
               state_in = init_ff ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_WCHAR: state_in = tcw_pkg::ST_WRAP;
         tcw_pkg::ST_WRAP: begin
            state_in = (caret_ff.x >= eff_c) ? tcw_pkg::ST_CHKROW : tcw_pkg::ST_AFTER;
         end
         tcw_pkg::ST_CHKROW: begin
            state_in = (caret_ff.y >= eff_r) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_AFTER;
         end
         tcw_pkg::ST_SCROLL: state_in = tcw_pkg::ST_ROWCLR;
         tcw_pkg::ST_ROWCLR: begin
            if (rowclr_last) state_in = tcw_pkg::ST_AFTER;
         end
         tcw_pkg::ST_AFTER: state_in = tcw_pkg::ST_DONE;
         tcw_pkg::ST_REDUCE: begin
            if (!row_big && !col_big) state_in = tcw_pkg::ST_READ;
         end
         tcw_pkg::ST_READ: state_in = tcw_pkg::ST_DONE;
         tcw_pkg::ST_DONE: begin
            if (rsp_free) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      cols_in     = cols_ff;
      rows_in     = rows_ff;
      fore_in     = fore_ff;
      back_in     = back_ff;
      caret_in    = caret_ff;
      top_in      = top_ff;
      dirty_in    = dirty_ff;
      mode_in     = mode_ff;
      wch_in      = wch_ff;
      bs_in       = bs_ff;
      nl_mark_in  = nl_mark_ff;
      init_in     = init_ff;
      rrow_in     = rrow_ff;
      rcol_in     = rcol_ff;
      sweep_in    = sweep_ff;
      col_cnt_in  = col_cnt_ff;
      clr_fore_in = clr_fore_ff;
      clr_back_in = clr_back_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_caret_col_in = rsp_caret_col_ff;
      rsp_caret_row_in = rsp_caret_row_ff;
      rsp_top_row_in   = rsp_top_row_ff;
      rsp_dv_in        = rsp_dv_ff;
      rsp_dcf_in       = rsp_dcf_ff;
      rsp_drf_in       = rsp_drf_ff;
      rsp_dce_in       = rsp_dce_ff;
      rsp_dre_in       = rsp_dre_ff;
      rsp_char_in      = rsp_char_ff;
      rsp_fore_in      = rsp_fore_ff;
      rsp_back_in      = rsp_back_ff;

      ch_we   = 1'b0;
      ch_wa   = cell_addr(ring_add(top_ff, RW'(caret_ff.y)), CW'(caret_ff.x));
      ch_wd   = wch_ff;
      co_we   = 1'b0;
      co_wa   = ch_wa;
      co_wd   = {fore_ff, back_ff};
      rd_en   = 1'b0;
      rd_addr = cell_addr(ring_add(top_ff, RW'(rrow_ff)), CW'(rcol_ff));

      // The user writes registers only while idle (not enforced), so no ordering with items.
      if (csr_we) begin
         case (csr_index)
            tcw_pkg::REG_COLS: cols_in = csr_wdata[7:0];
            tcw_pkg::REG_ROWS: rows_in = csr_wdata[6:0];
            tcw_pkg::REG_FORE: fore_in = csr_wdata;
            tcw_pkg::REG_BACK: back_in = csr_wdata;
            default:           cols_in = cols_ff;
         endcase
      end

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_xfer) begin
               mode_in = req_mode;
               rrow_in = req_read_row;
               rcol_in = req_read_col;
               bs_in   = 1'b0;
               case (req_mode)
                  tcw_pkg::MODE_PUT: begin
                     if (req_char_code == tcw_pkg::CODE_NL) begin
                        // Newline marks the cell it leaves but not the one it lands on.
                        dirty_in   = mark_at(dirty_ff, caret_ff.x, caret_ff.y);
                        caret_in.x = '0;
                        caret_in.y = caret_ff.y + RW1'(1);
                        nl_mark_in = 1'b0;
                     end else if (req_char_code == tcw_pkg::CODE_BS) begin
                        if (!bs_noop) begin
                           caret_in = step_back(caret_ff, eff_c);
                           wch_in   = tcw_pkg::CHAR_SPACE;
                           bs_in    = 1'b1;
                        end
                     end else if (req_char_code >= tcw_pkg::CODE_LIMIT) begin
                        wch_in = tcw_pkg::CHAR_BLOCK;
                     end else begin
                        wch_in = req_char_code[7:0];
                     end
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     sweep_in    = '0;
                     init_in     = 1'b0;
                     clr_fore_in = fore_ff;
                     clr_back_in = back_ff;
                  end
                  default: begin
                     sweep_in = sweep_ff;
                  end
               endcase
            end
         end
         tcw_pkg::ST_CLEAR: begin
            ch_we    = 1'b1;
            ch_wa    = sweep_ff;
            ch_wd    = tcw_pkg::CHAR_EMPTY;
            co_we    = 1'b1;
            co_wa    = sweep_ff;
            co_wd    = {clr_fore_ff, clr_back_ff};
            sweep_in = sweep_ff + AW'(1);
            if (sweep_last && !init_ff) begin
               caret_in.x     = '0;
               caret_in.y     = '0;
               dirty_in.empty = 1'b0;
               dirty_in.x0    = '0;
               dirty_in.y0    = '0;
               dirty_in.x1    = eff_c;
               dirty_in.y1    = eff_r;
            end
         end
         tcw_pkg::ST_WCHAR: begin
            dirty_in   = mark_at(dirty_ff, caret_ff.x, caret_ff.y);
            ch_we      = 1'b1;
            co_we      = 1'b1;
            caret_in.x = caret_ff.x + CW1'(1);
         end
         tcw_pkg::ST_WRAP: begin
            if (caret_ff.x >= eff_c) begin
               caret_in.x = '0;
               caret_in.y = caret_ff.y + RW1'(1);
               nl_mark_in = 1'b1;
            end else begin
               dirty_in = mark_at(dirty_ff, caret_ff.x, caret_ff.y);
            end
         end
         tcw_pkg::ST_CHKROW: begin
            if (caret_ff.y < eff_r && nl_mark_ff) begin
               dirty_in = mark_at(dirty_ff, caret_ff.x, caret_ff.y);
            end
         end
         tcw_pkg::ST_SCROLL: begin
            top_in = ring_add(top_ff, RW'(1));
            if (caret_ff.y != '0) caret_in.y = caret_ff.y - RW1'(1);
            dirty_in.empty = 1'b0;
            dirty_in.x0    = '0;
            dirty_in.y0    = '0;
            dirty_in.x1    = eff_c;
            dirty_in.y1    = eff_r;
            col_cnt_in     = '0;
         end
         tcw_pkg::ST_ROWCLR: begin
            // The new bottom screen row, every column of the ring row.
            ch_we      = 1'b1;
            ch_wa      = cell_addr(ring_add(top_ff, RW'(eff_r - RW1'(1))), col_cnt_ff);
            ch_wd      = tcw_pkg::CHAR_EMPTY;
            col_cnt_in = col_cnt_ff + CW'(1);
         end
         tcw_pkg::ST_AFTER: begin
            if (bs_ff) begin
               caret_in = step_back(caret_ff, eff_c);
               bs_in    = 1'b0;
            end
         end
         tcw_pkg::ST_REDUCE: begin
            if (row_big) rrow_in = rrow_ff - 6'(MAX_ROWS);
            if (col_big) rcol_in = rcol_ff - 7'(MAX_COLS);
         end
         tcw_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         tcw_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_caret_col_in = 7'(caret_ff.x);
               rsp_caret_row_in = 6'(caret_ff.y);
               rsp_top_row_in   = 6'(top_ff);
               rsp_dv_in        = 1'b0;
               rsp_dcf_in       = '0;
               rsp_drf_in       = '0;
               rsp_dce_in       = '0;
               rsp_dre_in       = '0;
               rsp_char_in      = '0;
               rsp_fore_in      = '0;
               rsp_back_in      = '0;
               if (mode_ff == tcw_pkg::MODE_TAKE) begin
                  if (!dirty_ff.empty) begin
                     rsp_dv_in  = 1'b1;
                     rsp_dcf_in = 7'(dirty_ff.x0);
                     rsp_drf_in = 6'(dirty_ff.y0);
                     rsp_dce_in = 8'(dirty_ff.x1);
                     rsp_dre_in = 7'(dirty_ff.y1);
                  end
                  dirty_in = '{empty: 1'b1, x0: '0, y0: '0, x1: '0, y1: '0};
               end else if (mode_ff == tcw_pkg::MODE_READ) begin
                  rsp_char_in = rd_char_ff;
                  rsp_fore_in = rd_color_ff[63:32];
                  rsp_back_in = rd_color_ff[31:0];
               end
            end
         end
         default: begin
            bs_in = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcw_pkg::ST_CLEAR;
         cols_ff        <= tcw_pkg::COLS_RST;
         rows_ff        <= tcw_pkg::ROWS_RST;
         fore_ff        <= tcw_pkg::FORE_RST;
         back_ff        <= tcw_pkg::BACK_RST;
         caret_ff       <= '0;
         top_ff         <= '0;
         dirty_ff.empty <= 1'b0;
         dirty_ff.x0    <= '0;
         dirty_ff.y0    <= '0;
         dirty_ff.x1    <= eff_cols_f(tcw_pkg::COLS_RST);
         dirty_ff.y1    <= eff_rows_f(tcw_pkg::ROWS_RST);
         bs_ff          <= 1'b0;
         nl_mark_ff     <= 1'b0;
         init_ff        <= 1'b1;
         sweep_ff       <= '0;
         col_cnt_ff     <= '0;
         clr_fore_ff    <= tcw_pkg::FORE_RST;
         clr_back_ff    <= tcw_pkg::BACK_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         fore_ff      <= fore_in;
         back_ff      <= back_in;
         caret_ff     <= caret_in;
         top_ff       <= top_in;
         dirty_ff     <= dirty_in;
         bs_ff        <= bs_in;
         nl_mark_ff   <= nl_mark_in;
         init_ff      <= init_in;
         sweep_ff     <= sweep_in;
         col_cnt_ff   <= col_cnt_in;
         clr_fore_ff  <= clr_fore_in;
         clr_back_ff  <= clr_back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      wch_ff           <= wch_in;
      rrow_ff          <= rrow_in;
      rcol_ff          <= rcol_in;
      rsp_caret_col_ff <= rsp_caret_col_in;
      rsp_caret_row_ff <= rsp_caret_row_in;
      rsp_top_row_ff   <= rsp_top_row_in;
      rsp_dv_ff        <= rsp_dv_in;
      rsp_dcf_ff       <= rsp_dcf_in;
      rsp_drf_ff       <= rsp_drf_in;
      rsp_dce_ff       <= rsp_dce_in;
      rsp_dre_ff       <= rsp_dre_in;
      rsp_char_ff      <= rsp_char_in;
      rsp_fore_ff      <= rsp_fore_in;
      rsp_back_ff      <= rsp_back_in;
   end

   // Cell memories: one write port each and one registered read.
   always_ff @(posedge clock) begin
      if (ch_we) char_mem[ch_wa] <= ch_wd;
      if (rd_en) rd_char_ff <= char_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (co_we) color_mem[co_wa] <= co_wd;
      if (rd_en) rd_color_ff <= color_mem[rd_addr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_caret_col       = rsp_caret_col_ff;
   assign rsp_caret_row       = rsp_caret_row_ff;
   assign rsp_top_row         = rsp_top_row_ff;
   assign rsp_dirty_valid     = rsp_dv_ff;
   assign rsp_dirty_col_first = rsp_dcf_ff;
   assign rsp_dirty_row_first = rsp_drf_ff;
   assign rsp_dirty_col_end   = rsp_dce_ff;
   assign rsp_dirty_row_end   = rsp_dre_ff;
   assign rsp_cell_char       = rsp_char_ff;
   assign rsp_cell_fore       = rsp_fore_ff;
   assign rsp_cell_back       = rsp_back_ff;

   // A transfer in starts work, so the input side closes on the next cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("input still open after a transfer");

   // Between items the caret lies inside the store.
   a_caret_range: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (32'(caret_ff.x) < MAX_COLS) && (32'(caret_ff.y) < MAX_ROWS))
      else $error("caret outside the store between items");

   // A non-empty dirty rectangle always has positive extent.
   a_dirty_extent: assert property (@(posedge clock) disable iff (reset)
      !dirty_ff.empty |-> (CW1'(dirty_ff.x0) < dirty_ff.x1) &&
                          (RW1'(dirty_ff.y0) < dirty_ff.y1))
      else $error("dirty rectangle with no extent");

   // A pending result is never overwritten before its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_caret_col_ff))
      else $error("pending result changed");

endmodule
